/* rtl/core/nlcc_pkg.sv */
`default_nettype none

package nlcc_pkg;

    localparam int MAX_LINE   = 512;
    localparam int POS_W      = $clog2(MAX_LINE + 1);
    localparam int LEN_W      = 10;
    localparam int BYTE_W     = 8;
    localparam int MIN_LINE   = 5;
    localparam int PREFIX_LEN = 4;

    localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_STAR = 8'h2A;

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_PREFIX    = 3'd1,
        VERDICT_NO_SUM    = 3'd2,
        VERDICT_BAD_SUM   = 3'd3,
        VERDICT_TOO_SHORT = 3'd4,
        VERDICT_TOO_LONG  = 3'd5
    } verdict_t;

    typedef enum logic [3:0] {
        PHASE_BODY = 4'b0001,
        PHASE_HEX  = 4'b0010,
        PHASE_TAIL = 4'b0100,
        PHASE_LONG = 4'b1000
    } phase_t;

    typedef struct packed {
        verdict_t          verdict;
        logic [LEN_W-1:0]  line_length;
        logic [BYTE_W-1:0] computed_sum;
        logic [BYTE_W-1:0] received_sum;
    } result_t;

    function automatic logic [BYTE_W-1:0] lead_char(input logic [1:0] idx);
        logic [BYTE_W-1:0] c;
        unique case (idx)
            2'd0: c = 8'h21;
            2'd1: c = 8'h41;
            2'd2: c = 8'h49;
            2'd3: c = 8'h56;
            default: c = 8'h21;
        endcase
        return c;
    endfunction

    // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [4:0] d;
        d = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            d = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            d = {1'b1, 4'(c - 8'h37)};
        end
        return d;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/nlcc_ifs.sv */
`default_nettype none

interface nlcc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface nlcc_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    logic [9:0] line_length;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;

    modport source (output valid, output verdict, output line_length,
                    output computed_sum, output received_sum, input ready);
    modport sink (input valid, input verdict, input line_length,
                  input computed_sum, input received_sum, output ready);
endinterface

`default_nettype wire

/* rtl/core/nlcc_line_parser.sv */
`default_nettype none

module nlcc_line_parser (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [nlcc_pkg::BYTE_W-1:0] rx_byte,
    output logic                             res_valid,
    output nlcc_pkg::result_t                res
);

    localparam logic [nlcc_pkg::POS_W:0] MAX_EXT = (nlcc_pkg::POS_W + 1)'(nlcc_pkg::MAX_LINE);

    logic [nlcc_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                        prefix_ok_reg, prefix_ok_next;
    logic [nlcc_pkg::BYTE_W-1:0] xor_reg, xor_next;
    nlcc_pkg::phase_t            phase_reg, phase_next;
    logic [nlcc_pkg::BYTE_W-1:0] hex_reg, hex_next;
    logic                        ovf_reg, ovf_next;
    logic                        star_reg, star_next;

    logic [nlcc_pkg::POS_W:0] pos_inc;
    logic [4:0]               digit;
    logic                     is_long;

    assign pos_inc = {1'b0, pos_reg} + 1'b1;
    assign digit   = nlcc_pkg::hex_digit(rx_byte);
    assign is_long = (phase_reg == nlcc_pkg::PHASE_LONG) || ({1'b0, pos_reg} >= MAX_EXT);

    always_comb
    begin
        res.computed_sum = xor_reg;
        res.received_sum = hex_reg;
        if (is_long) begin
            res.verdict     = nlcc_pkg::VERDICT_TOO_LONG;
            res.line_length = nlcc_pkg::LEN_W'(nlcc_pkg::MAX_LINE);
        end
        else begin
            res.line_length = nlcc_pkg::LEN_W'(pos_inc);
            if (pos_inc < (nlcc_pkg::POS_W + 1)'(nlcc_pkg::MIN_LINE)) begin
                res.verdict = nlcc_pkg::VERDICT_TOO_SHORT;
            end
            else if (!prefix_ok_reg) begin
                res.verdict = nlcc_pkg::VERDICT_PREFIX;
            end
            else if (!star_reg) begin
                res.verdict = nlcc_pkg::VERDICT_NO_SUM;
            end
            else if (ovf_reg || (hex_reg != xor_reg)) begin
                res.verdict = nlcc_pkg::VERDICT_BAD_SUM;
            end
            else begin
                res.verdict = nlcc_pkg::VERDICT_OK;
            end
        end
    end

    assign res_valid = accept && (rx_byte == nlcc_pkg::CHAR_LF);

    always_comb
    begin
        pos_next       = pos_reg;
        prefix_ok_next = prefix_ok_reg;
        xor_next       = xor_reg;
        phase_next     = phase_reg;
        hex_next       = hex_reg;
        ovf_next       = ovf_reg;
        star_next      = star_reg;
        if (accept) begin
            if (rx_byte == nlcc_pkg::CHAR_LF) begin
                pos_next       = '0;
                prefix_ok_next = 1'b1;
                xor_next       = '0;
                phase_next     = nlcc_pkg::PHASE_BODY;
                hex_next       = '0;
                ovf_next       = 1'b0;
                star_next      = 1'b0;
            end
            else if (phase_reg == nlcc_pkg::PHASE_LONG) begin
                phase_next = nlcc_pkg::PHASE_LONG;
            end
            else if (pos_inc >= MAX_EXT) begin
                phase_next = nlcc_pkg::PHASE_LONG;
                pos_next   = nlcc_pkg::POS_W'(nlcc_pkg::MAX_LINE);
            end
            else begin
                pos_next = nlcc_pkg::POS_W'(pos_inc);
                if (pos_reg < nlcc_pkg::POS_W'(nlcc_pkg::PREFIX_LEN)
                    && rx_byte != nlcc_pkg::lead_char(pos_reg[1:0])) begin
                    prefix_ok_next = 1'b0;
                end
                if (pos_reg != '0) begin
                    unique case (phase_reg)
                        nlcc_pkg::PHASE_BODY:
                        begin
                            if (rx_byte == nlcc_pkg::CHAR_STAR) begin
                                star_next  = 1'b1;
                                phase_next = nlcc_pkg::PHASE_HEX;
                            end
                            else if (rx_byte == nlcc_pkg::CHAR_CR) begin
                                phase_next = nlcc_pkg::PHASE_TAIL;
                            end
                            else begin
                                xor_next = xor_reg ^ rx_byte;
                            end
                        end
                        nlcc_pkg::PHASE_HEX:
                        begin
                            if (!digit[4]) begin
                                phase_next = nlcc_pkg::PHASE_TAIL;
                            end
                            else begin
                                if (hex_reg[7:4] != 4'd0) begin
                                    ovf_next = 1'b1;
                                end
                                hex_next = {hex_reg[3:0], digit[3:0]};
                            end
                        end
                        nlcc_pkg::PHASE_TAIL:
                        begin
                            phase_next = nlcc_pkg::PHASE_TAIL;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg       <= '0;
            prefix_ok_reg <= 1'b1;
            xor_reg       <= '0;
            phase_reg     <= nlcc_pkg::PHASE_BODY;
            hex_reg       <= '0;
            ovf_reg       <= 1'b0;
            star_reg      <= 1'b0;
        end
        else begin
            pos_reg       <= pos_next;
            prefix_ok_reg <= prefix_ok_next;
            xor_reg       <= xor_next;
            phase_reg     <= phase_next;
            hex_reg       <= hex_next;
            ovf_reg       <= ovf_next;
            star_reg      <= star_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/nlcc_result_stage.sv */
`default_nettype none

module nlcc_result_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire nlcc_pkg::result_t res,
    output logic                   room,
    nlcc_result_if.source          result
);

    logic              valid_reg, valid_next;
    nlcc_pkg::result_t data_reg;

    // A new result may enter when the stage is empty or its transaction completes now.
    assign room = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end
        else if (result.ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign result.valid        = valid_reg;
    assign result.verdict      = data_reg.verdict;
    assign result.line_length  = data_reg.line_length;
    assign result.computed_sum = data_reg.computed_sum;
    assign result.received_sum = data_reg.received_sum;

endmodule

`default_nettype wire

/* rtl/core/nmea_line_checksum_checker.sv */
// A verdict is registered and is valid in the cycle after the transaction that carries the newline.
// Throughput: one byte per cycle while the input is not stalled; the line state updates once per accepted byte.
// Input is stalled only while a verdict waits in the output register and is not taken.
// Reset (rst_n low, asynchronous) clears the line state and drops any pending verdict.
`default_nettype none

module nmea_line_checksum_checker (
    input  wire logic     clk,
    input  wire logic     rst_n,
    nlcc_byte_if.sink     rx,
    nlcc_result_if.source result
);

    logic              accept;
    logic              room;
    logic              res_valid;
    nlcc_pkg::result_t res;

    assign rx.ready = room;
    assign accept   = rx.valid && room;

    nlcc_line_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx.rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    nlcc_result_stage u_result (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (res_valid),
        .res    (res),
        .room   (room),
        .result (result)
    );

    a_newline_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        rx.valid && rx.ready && rx.rx_byte == nlcc_pkg::CHAR_LF |=> result.valid)
        else $error("newline did not produce a verdict");

    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.verdict <= 3'(nlcc_pkg::VERDICT_TOO_LONG))
        else $error("verdict code out of range");

    a_long_length: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.verdict == 3'(nlcc_pkg::VERDICT_TOO_LONG)
        |-> result.line_length == nlcc_pkg::LEN_W'(nlcc_pkg::MAX_LINE))
        else $error("overlong line reports wrong length");

    a_ok_sums_match: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.verdict == 3'(nlcc_pkg::VERDICT_OK)
        |-> result.computed_sum == result.received_sum
            && result.line_length >= nlcc_pkg::LEN_W'(nlcc_pkg::MIN_LINE))
        else $error("accepted line with mismatching checksum or short length");

endmodule

`default_nettype wire
